[design/hbs_pkg.sv]
// shared types and constants for the heightmap bilinear sampler
package hbs_pkg;

  localparam int DEF_GRID_COLS = 256;
  localparam int DEF_GRID_ROWS = 256;

  localparam int HEIGHT_W   = 24;
  localparam int RES_W      = 16;
  localparam int LIM_W      = 9;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W     = 16;
  localparam int MUL_W      = HEIGHT_W + RES_W + 1;
  localparam int COORD_W    = MUL_W - FRAC_W;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int DIFF_W     = HEIGHT_W + 1;
  localparam int ROWV_W     = HEIGHT_W + FRAC_W + 2;
  localparam int SUM_W      = HEIGHT_W + 2 * FRAC_W + 2;
  localparam int RESV_W     = SUM_W - 2 * FRAC_W;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd2;

  localparam logic [RES_W-1:0] RESOLUTION_RESET = 16'd256;
  localparam logic [LIM_W-1:0] COLS_RESET       = 9'd256;
  localparam logic [LIM_W-1:0] ROWS_RESET       = 9'd256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef logic signed [HEIGHT_W-1:0] height_t;

  localparam height_t OUTSIDE_HEIGHT = -24'sd256;
  localparam height_t H_MAX          = 24'sh7FFFFF;
  localparam height_t H_MIN          = 24'sh800000;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (2 * FRAC_W - 1));

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    height_t          height;
    height_t          x_pos;
    height_t          y_pos;
  } hbs_req_t;

  typedef struct packed {
    height_t height_out;
    logic    corner_outside;
    logic    saturated;
  } hbs_rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] upper;
    logic [WEIGHT_W-1:0]       weight;
  } hbs_axis_t;

endpackage

[design/hbs_grid_mem.sv]
// single-port height grid memory with registered read data
module hbs_grid_mem #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  hbs_pkg::height_t  wdata,
  output hbs_pkg::height_t  rdata
);
  import hbs_pkg::*;

  height_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[design/hbs_axis.sv]
// maps one world coordinate to upper grid corner and weight toward it
module hbs_axis (
  input  logic                       clk,
  input  logic                       en,
  input  hbs_pkg::height_t           pos,
  input  logic [hbs_pkg::RES_W-1:0]  resolution,
  output hbs_pkg::hbs_axis_t         axis
);
  import hbs_pkg::*;

  logic signed [MUL_W-1:0]   grid;
  logic signed [COORD_W-1:0] base;
  logic                      frac_zero;

  assign grid      = MUL_W'(pos * $signed({1'b0, resolution}));
  assign base      = grid[MUL_W-1:FRAC_W];
  assign frac_zero = (grid[FRAC_W-1:0] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      axis.upper  <= frac_zero ? base : base + COORD_W'(1);
      axis.weight <= frac_zero ? WEIGHT_ONE : {1'b0, grid[FRAC_W-1:0]};
    end
  end

endmodule

[design/heightmap_bilinear_sampler.sv]
// Heightmap bilinear sampler: a write request stores one signed Q16.8 height
// in a single-port grid memory as it is accepted and gives no response. A
// sample request scales its Q16.8 position by the Q8.8 resolution, reads the
// four surrounding corners one per cycle from the grid memory (corners outside
// the rows and columns in use read as -1.0), blends them with two row lerps
// and one column lerp, rounds and saturates. A sample steps through S_MAP for
// the coordinate multiply, S_RD0 to S_RD3 for the memory reads on the one
// port, S_RD4 for the last read to return, then S_ROWB, S_LERP and S_FIN for
// the blend, S_FIN loading the response once the output register is free.
// Requests are taken one at a time, the next only back in idle; a finished
// response waits in the output register. The memory needs no clearing after reset.
module heightmap_bilinear_sampler #(
  parameter int GRID_COLS = hbs_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = hbs_pkg::DEF_GRID_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  hbs_pkg::hbs_req_t                 req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output hbs_pkg::hbs_rsp_t                 rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hbs_pkg::*;

  localparam int COL_AW = $clog2(GRID_COLS);
  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int ADDR_W = ROW_AW + COL_AW;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_ROWB, S_LERP, S_FIN
  } state_t;

  state_t state;

  logic [RES_W-1:0] resolution;
  logic [LIM_W-1:0] cols_in_use;
  logic [LIM_W-1:0] rows_in_use;

  height_t   pos_x, pos_y;
  hbs_axis_t ax_x, ax_y;
  logic      map_en;

  logic                      write_go, wr_in_range;
  logic                      rd_state;
  logic [1:0]                corner_k;
  logic signed [COORD_W-1:0] r_idx, c_idx;
  logic [COORD_W-1:0]        row_lim, col_lim;
  logic                      corner_out, corner_out_q, outside_acc;
  logic                      mem_en;
  logic [ADDR_W-1:0]         mem_addr, wr_addr, rd_addr;
  height_t                   mem_rdata, h_eff, h_lo;

  logic signed [DIFF_W-1:0]       diff_row;
  logic signed [DIFF_W+WEIGHT_W:0] mul_row;
  logic signed [ROWV_W-1:0]       prod_row, row_a, row_b, diff_f;
  logic signed [ROWV_W+WEIGHT_W:0] mul_f;
  logic signed [SUM_W-1:0]        row_a_s, prod_f, sum_f;
  logic signed [RESV_W-1:0]       res;
  logic [RESV_W-HEIGHT_W:0]       top_bits;
  logic                           fits;
  height_t                        res_sat;

  // configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution  <= RESOLUTION_RESET;
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RESOLUTION:  resolution  <= cfg_data[RES_W-1:0];
        CFG_COLS_IN_USE: cols_in_use <= cfg_data[LIM_W-1:0];
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate mapping
  assign map_en = (state == S_MAP);

  hbs_axis u_axis_x (
    .clk        (clk),
    .en         (map_en),
    .pos        (pos_x),
    .resolution (resolution),
    .axis       (ax_x)
  );

  hbs_axis u_axis_y (
    .clk        (clk),
    .en         (map_en),
    .pos        (pos_y),
    .resolution (resolution),
    .axis       (ax_y)
  );

  // corner addressing and bounds
  assign req_ready = !rst && (state == S_IDLE);
  assign wr_in_range = (32'(req.row) < GRID_ROWS) && (32'(req.col) < GRID_COLS);
  assign write_go = req_valid && req_ready && (req.func == FUNC_WRITE) && wr_in_range;
  assign rd_state = (state == S_RD0) || (state == S_RD1) ||
                    (state == S_RD2) || (state == S_RD3);

  always_comb begin
    unique case (state)
      S_RD1:   corner_k = 2'd1;
      S_RD2:   corner_k = 2'd2;
      S_RD3:   corner_k = 2'd3;
      default: corner_k = 2'd0;
    endcase
  end

  assign r_idx = corner_k[1] ? ax_y.upper : ax_y.upper - COORD_W'(1);
  assign c_idx = corner_k[0] ? ax_x.upper : ax_x.upper - COORD_W'(1);

  assign row_lim = (COORD_W'(rows_in_use) < COORD_W'(GRID_ROWS)) ?
                   COORD_W'(rows_in_use) : COORD_W'(GRID_ROWS);
  assign col_lim = (COORD_W'(cols_in_use) < COORD_W'(GRID_COLS)) ?
                   COORD_W'(cols_in_use) : COORD_W'(GRID_COLS);

  assign corner_out = r_idx[COORD_W-1] || c_idx[COORD_W-1] ||
                      ($unsigned(r_idx) >= row_lim) || ($unsigned(c_idx) >= col_lim);

  assign wr_addr  = {ROW_AW'(req.row), COL_AW'(req.col)};
  assign rd_addr  = {r_idx[ROW_AW-1:0], c_idx[COL_AW-1:0]};
  assign mem_en   = write_go || rd_state;
  assign mem_addr = write_go ? wr_addr : rd_addr;

  hbs_grid_mem #(
    .ADDR_W (ADDR_W)
  ) u_grid_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (write_go),
    .addr  (mem_addr),
    .wdata (req.height),
    .rdata (mem_rdata)
  );

  // blend datapath
  assign h_eff    = corner_out_q ? OUTSIDE_HEIGHT : mem_rdata;
  assign diff_row = DIFF_W'(h_eff) - DIFF_W'(h_lo);
  assign mul_row  = diff_row * $signed({1'b0, ax_x.weight});
  assign diff_f   = row_b - row_a;
  assign mul_f    = diff_f * $signed({1'b0, ax_y.weight});

  assign sum_f    = row_a_s + prod_f;
  assign res      = sum_f[SUM_W-1:2*FRAC_W];
  assign top_bits = res[RESV_W-1:HEIGHT_W-1];
  assign fits     = (&top_bits) || !(|top_bits);
  assign res_sat  = fits ? res[HEIGHT_W-1:0] : (res[RESV_W-1] ? H_MIN : H_MAX);

  always_ff @(posedge clk) begin
    corner_out_q <= corner_out;
    if (req_valid && req_ready) begin
      pos_x <= req.x_pos;
      pos_y <= req.y_pos;
    end
    if (rd_state) begin
      outside_acc <= (state == S_RD0) ? corner_out : (outside_acc || corner_out);
    end
    case (state)
      S_RD1: h_lo <= h_eff;
      S_RD2: prod_row <= ROWV_W'(mul_row);
      S_RD3: begin
        h_lo  <= h_eff;
        row_a <= (ROWV_W'(h_lo) <<< FRAC_W) + prod_row;
      end
      S_RD4: prod_row <= ROWV_W'(mul_row);
      S_ROWB: begin
        row_b   <= (ROWV_W'(h_lo) <<< FRAC_W) + prod_row;
        row_a_s <= (SUM_W'(row_a) <<< FRAC_W) + ROUND_HALF;
      end
      S_LERP: prod_f <= SUM_W'(mul_f);
      default: ;
    endcase
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && req.func == FUNC_SAMPLE) begin
            state <= S_MAP;
          end
        end
        S_MAP:  state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_RD3;
        S_RD3:  state <= S_RD4;
        S_RD4:  state <= S_ROWB;
        S_ROWB: state <= S_LERP;
        S_LERP: state <= S_FIN;
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.height_out     <= res_sat;
            rsp.corner_outside <= outside_acc;
            rsp.saturated      <= !fits;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> (ax_x.weight != '0) && (ax_x.weight <= WEIGHT_ONE) &&
                         (ax_y.weight != '0) && (ax_y.weight <= WEIGHT_ONE))
    else $error("corner weight out of range");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.func == FUNC_SAMPLE) |=> (state == S_MAP))
    else $error("sample request did not start mapping");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.saturated) |-> (rsp.height_out == H_MAX || rsp.height_out == H_MIN))
    else $error("saturated response not at a range limit");

endmodule

[dv/heightmap_bilinear_sampler_test.sv]
// self-checking testbench for the heightmap bilinear sampler with its own blend predictor
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;

  localparam int GRID_COLS      = DEF_GRID_COLS;
  localparam int GRID_ROWS      = DEF_GRID_ROWS;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int FILL_SPAN      = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  hbs_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hbs_rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies and grid contents as the block should hold them
  logic [RES_W-1:0] cfg_res = RESOLUTION_RESET;
  logic [LIM_W-1:0] cfg_cols = COLS_RESET;
  logic [LIM_W-1:0] cfg_rows = ROWS_RESET;
  height_t grid_heights [GRID_ROWS*GRID_COLS];
  bit grid_filled [GRID_ROWS*GRID_COLS];

  hbs_req_t pending_requests [$];
  hbs_rsp_t expected_samples [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int rx_hold_arm = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int writes_done = 0;
  int samples_done = 0;
  int outside_samples = 0;
  int settings_used = 0;

  heightmap_bilinear_sampler #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint axis_limit(input logic [LIM_W-1:0] in_use, input int grid);
    return (in_use < grid) ? longint'(in_use) : longint'(grid);
  endfunction

  function automatic bit cell_inside(input longint r, input longint c);
    return r >= 0 && c >= 0 && r < axis_limit(cfg_rows, GRID_ROWS) &&
           c < axis_limit(cfg_cols, GRID_COLS);
  endfunction

  // upper corner index and weight toward it, weight in 1..65536
  function automatic void axis_cell(input height_t pos, output longint upper,
                                    output longint weight);
    longint g;
    g = longint'(pos) * longint'(cfg_res);
    upper = (g + 65535) >>> 16;
    weight = g - (upper - 1) * 65536;
  endfunction

  function automatic longint corner_height(input longint r, input longint c,
                                           inout logic outside);
    if (!cell_inside(r, c)) begin
      outside = 1'b1;
      return longint'(OUTSIDE_HEIGHT);
    end
    return longint'(grid_heights[r * GRID_COLS + c]);
  endfunction

  function automatic hbs_rsp_t blend_sample(input hbs_req_t rq);
    longint ux, wx, uy, wy, ax, ay, sum, val;
    longint h1, h2, h3, h4;
    logic outside;
    hbs_rsp_t rs;
    axis_cell(rq.x_pos, ux, wx);
    axis_cell(rq.y_pos, uy, wy);
    outside = 1'b0;
    h1 = corner_height(uy - 1, ux - 1, outside);
    h2 = corner_height(uy - 1, ux, outside);
    h3 = corner_height(uy, ux - 1, outside);
    h4 = corner_height(uy, ux, outside);
    ax = 65536 - wx;
    ay = 65536 - wy;
    sum = ax * ay * h1 + wx * ay * h2 + ax * wy * h3 + wx * wy * h4;
    val = (sum + (longint'(1) <<< 31)) >>> 32;
    rs.saturated = 1'b0;
    if (val > longint'(H_MAX)) begin
      val = longint'(H_MAX);
      rs.saturated = 1'b1;
    end
    if (val < longint'(H_MIN)) begin
      val = longint'(H_MIN);
      rs.saturated = 1'b1;
    end
    rs.height_out = height_t'(val);
    rs.corner_outside = outside;
    return rs;
  endfunction

  // a sample may only touch grid entries that already hold a height
  function automatic bit cell_known(input longint r, input longint c);
    return !cell_inside(r, c) || grid_filled[r * GRID_COLS + c];
  endfunction

  function automatic bit sample_legal(input height_t x, input height_t y);
    longint ux, wx, uy, wy;
    axis_cell(x, ux, wx);
    axis_cell(y, uy, wy);
    return cell_known(uy - 1, ux - 1) && cell_known(uy - 1, ux) &&
           cell_known(uy, ux - 1) && cell_known(uy, ux);
  endfunction

  function automatic height_t random_height();
    case ($urandom_range(0, 9))
      0: return H_MAX;
      1: return H_MIN;
      default: return height_t'($urandom);
    endcase
  endfunction

  function automatic hbs_req_t make_write(input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c, input height_t h);
    hbs_req_t it;
    it.func = FUNC_WRITE;
    it.row = r;
    it.col = c;
    it.height = h;
    it.x_pos = height_t'($urandom);
    it.y_pos = height_t'($urandom);
    grid_filled[int'(r) * GRID_COLS + int'(c)] = 1'b1;
    return it;
  endfunction

  function automatic hbs_req_t make_sample(input height_t x, input height_t y);
    hbs_req_t it;
    it.func = FUNC_SAMPLE;
    it.row = IDX_W'($urandom);
    it.col = IDX_W'($urandom);
    it.height = height_t'($urandom);
    it.x_pos = x;
    it.y_pos = y;
    return it;
  endfunction

  // world position whose grid coordinate lands near a chosen corner
  function automatic height_t aim_axis(input longint lim);
    longint k, t, p;
    case ($urandom_range(0, 9))
      0: k = longint'($urandom_range(0, 3)) - 2;
      1: k = lim + longint'($urandom_range(0, 2)) - 1;
      2: k = 254 + longint'($urandom_range(0, 3));
      default: k = longint'($urandom_range(0, FILL_SPAN - 1));
    endcase
    t = k * 65536;
    if ($urandom_range(0, 7) != 0) t = t - longint'($urandom_range(1, 65535));
    if (cfg_res == 0) return height_t'($urandom);
    p = t / longint'(cfg_res);
    if (p > longint'(H_MAX)) p = longint'(H_MAX);
    if (p < longint'(H_MIN)) p = longint'(H_MIN);
    return height_t'(p);
  endfunction

  function automatic hbs_req_t random_item();
    int pick, tries;
    height_t x, y;
    logic [IDX_W-1:0] r, c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 4) != 0) begin
        r = IDX_W'($urandom_range(0, FILL_SPAN - 1));
        c = IDX_W'($urandom_range(0, FILL_SPAN - 1));
      end else begin
        r = IDX_W'($urandom);
        c = IDX_W'($urandom);
      end
      return make_write(r, c, random_height());
    end
    for (tries = 0; tries < 40; tries++) begin
      if (pick < 37) begin
        x = height_t'($urandom);
        y = height_t'($urandom);
      end else begin
        x = aim_axis(axis_limit(cfg_cols, GRID_COLS));
        y = aim_axis(axis_limit(cfg_rows, GRID_ROWS));
      end
      if (sample_legal(x, y)) return make_sample(x, y);
    end
    return make_sample('0, '0);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] limit_data(input int v);
    return {7'($urandom), LIM_W'(v)};
  endfunction

  function automatic int random_limit();
    case ($urandom_range(0, 9))
      0: return $urandom_range(257, 511);
      1: return $urandom_range(0, 2);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_resolution();
    return $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(128, 640))
                                : CFG_DATA_W'($urandom_range(1, 65535));
  endfunction

  task automatic queue_random(input int n);
    repeat (n) pending_requests.push_back(random_item());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RESOLUTION: cfg_res = val;
      CFG_COLS_IN_USE: cfg_cols = val[LIM_W-1:0];
      CFG_ROWS_IN_USE: cfg_rows = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idle(input int mode);
    @(negedge clk);
    case (mode)
      1: begin send_idle_pct = 60; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 60; end
      3: begin send_idle_pct = 38; recv_stall_pct = 38; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // wait until every request is taken and every sample answered, then let writes finish
  task automatic settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_valid || expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] res, input logic [CFG_DATA_W-1:0] cols,
                           input logic [CFG_DATA_W-1:0] rows, input int mode, input int n);
    settle();
    write_reg(CFG_RESOLUTION, res);
    write_reg(CFG_COLS_IN_USE, cols);
    write_reg(CFG_ROWS_IN_USE, rows);
    settings_used++;
    set_idle(mode);
    queue_random(n);
  endtask

  // request driver
  always @(posedge clk) begin
    logic free;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      free = !req_valid || req_ready;
      if (req_valid && req_ready) begin
        if (req.func == FUNC_WRITE) begin
          if (int'(req.row) < GRID_ROWS && int'(req.col) < GRID_COLS)
            grid_heights[int'(req.row) * GRID_COLS + int'(req.col)] = req.height;
          writes_done++;
        end else begin
          expected_samples.push_back(blend_sample(req));
          if (expected_samples[$].corner_outside) outside_samples++;
          samples_done++;
        end
      end
      if (free) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_arm != rx_hold_seen) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_seen <= rx_hold_arm;
    end
  end

  // response monitor
  always @(posedge clk) begin
    hbs_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: height_out=%0d corner_outside=%0b saturated=%0b",
                     rsp.height_out, rsp.corner_outside, rsp.saturated);
        end else begin
          want = expected_samples.pop_front();
          if (rsp.height_out !== want.height_out || rsp.corner_outside !== want.corner_outside ||
              rsp.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected height_out=%0d corner_outside=%0b saturated=%0b, got %0d %0b %0b",
                       want.height_out, want.corner_outside, want.saturated,
                       rsp.height_out, rsp.corner_outside, rsp.saturated);
          end
        end
      end
      rsp_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("heightmap_bilinear_sampler_test: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_idle(0);

    // corners at both ends of the grid, extreme heights
    pending_requests.push_back(make_write(8'd0, 8'd0, H_MAX));
    pending_requests.push_back(make_write(8'd0, 8'd1, H_MIN));
    pending_requests.push_back(make_write(8'd1, 8'd0, 24'sh000100));
    pending_requests.push_back(make_write(8'd1, 8'd1, -24'sh000300));
    pending_requests.push_back(make_write(8'd255, 8'd255, 24'sh123456));
    pending_requests.push_back(make_write(8'd255, 8'd254, random_height()));
    pending_requests.push_back(make_write(8'd254, 8'd255, random_height()));
    pending_requests.push_back(make_write(8'd254, 8'd254, random_height()));
    pending_requests.push_back(make_write(8'hAA, 8'h55, 24'shAAAAAA));
    // origin: all weight on upper corner, three corners off the grid
    pending_requests.push_back(make_sample(24'sd0, 24'sd0));
    // exact integer coordinate
    pending_requests.push_back(make_sample(24'sd256, 24'sd256));
    // midpoint blend of the four corners above, including the max and min heights
    pending_requests.push_back(make_sample(24'sd128, 24'sd128));
    pending_requests.push_back(make_sample(24'sd1, 24'sd255));
    // last row and column, then just past them
    pending_requests.push_back(make_sample(24'sd65280, 24'sd65280));
    pending_requests.push_back(make_sample(24'sd65408, 24'sd65408));
    // extreme positions
    pending_requests.push_back(make_sample(H_MAX, H_MAX));
    pending_requests.push_back(make_sample(H_MIN, H_MIN));
    pending_requests.push_back(make_sample(-24'sd128, 24'sd0));
    pending_requests.push_back(make_sample(H_MAX, 24'sd0));
    settle();

    // fill a block of the grid so that samples land on known heights
    for (int r = 0; r < FILL_SPAN; r++)
      for (int c = 0; c < FILL_SPAN; c++)
        pending_requests.push_back(make_write(IDX_W'(r), IDX_W'(c), random_height()));
    queue_random(60);
    settings_used++;

    run_phase(16'd300, limit_data(256), limit_data(256), 0, 140);
    run_phase(16'hFFFF, limit_data(1), limit_data(1), 1, 140);
    run_phase(16'd1, limit_data(511), limit_data(300), 2, 120);
    settle();
    write_reg(CFG_SPARE, 16'hFFFF);
    set_idle(2);
    queue_random(20);
    run_phase(16'd0, limit_data(random_limit()), limit_data(random_limit()), 3, 140);
    run_phase(random_resolution(), limit_data(0), limit_data(17), 0, 140);

    // receiver holds off while requests keep coming, then the sender waits for a full drain
    run_phase(16'd256, limit_data(FILL_SPAN), limit_data(FILL_SPAN), 0, 0);
    @(negedge clk);
    rx_hold_arm++;
    queue_random(40);
    do @(negedge clk); while (rx_hold_left == 0);
    do @(negedge clk); while (rx_hold_left != 0);
    settle();
    @(negedge clk);
    queue_random(100);

    for (int p = 0; p < 6; p++)
      run_phase(random_resolution(), limit_data(random_limit()), limit_data(random_limit()),
                p % 4, 100);
    settle();

    $display("run covered %0d grid writes and %0d samples, %0d touching off-grid corners,",
             writes_done, samples_done, outside_samples);
    $display("over %0d register settings and four idle patterns in %0d cycles",
             settings_used, cycle_count);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("heightmap_bilinear_sampler_test: PASS");
    end else begin
      $display("heightmap_bilinear_sampler_test: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/hbs_pkg.sv
design/hbs_grid_mem.sv
design/hbs_axis.sv
design/heightmap_bilinear_sampler.sv
dv/heightmap_bilinear_sampler_test.sv
